@@ src/rcfd_pkg.sv @@
// Package for the remote-control frame decoder: sizes, codes, the frame and
// configuration types. Used by every module of the block; depends on nothing.
package rcfd_pkg;

  localparam int FRAME_BYTES  = 18;
  localparam int BUFFER_BYTES = 36;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int IDX_W        = $clog2(FRAME_BYTES);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] FRAME_COUNT  = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] BUFFER_COUNT = CNT_W'(BUFFER_BYTES);

  localparam logic signed [11:0] COMBO_LOW  = -12'sd660;
  localparam logic signed [11:0] COMBO_HIGH = 12'sd660;

  localparam logic [10:0] RAW_MASK = 11'h7ff;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_SWITCH_INDEX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_UP_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_MID_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DOWN_CODE  = 3'd5;

  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_KEYBOARD_MOUSE = 2'd1;
  localparam logic [1:0] MODE_REMOTE = 2'd2;

  localparam logic [1:0] EV_VALID   = 2'd0;
  localparam logic [1:0] EV_CORRUPT = 2'd1;
  localparam logic [1:0] EV_COMBO   = 2'd2;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [10:0] channel_offset;
    logic [10:0] error_limit;
    logic        mode_switch_index;
    logic [1:0]  switch_up_code;
    logic [1:0]  switch_mid_code;
    logic [1:0]  switch_down_code;
  } cfg_t;

endpackage

@@ src/rc_receiver_frame_decoder_core.sv @@
// Top level of the remote-control frame decoder: configuration registers and
// the front end, frame queue and decoder. Depends on rcfd_pkg and its modules.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     rx_byte, line_idle
//   out_     output     out_valid / out_ready   sticks, wheel, switches, mouse, keys, mode, event
//   cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// One input transaction is taken every cycle; a byte is never stalled, and an
// idle mark waits only while the two-entry frame queue is full.
// A frame enters the queue when its idle mark is accepted, and is decoded and registered
// at the edge that pops it from the queue; that same edge raises out_valid.
// Reset (rst_n low, synchronous) clears the byte count, queue, mode and output
// valid and loads the register defaults; the frame store needs no clearing.
module rc_receiver_frame_decoder_core import rcfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  input  logic                  in_line_idle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [11:0]    out_stick_ch0,
  output logic signed [11:0]    out_stick_ch1,
  output logic signed [11:0]    out_stick_ch2,
  output logic signed [11:0]    out_stick_ch3,
  output logic signed [15:0]    out_wheel,
  output logic        [3:0]     out_switches,
  output logic signed [15:0]    out_mouse_x,
  output logic signed [15:0]    out_mouse_y,
  output logic signed [15:0]    out_mouse_z,
  output logic        [17:0]    out_keys_buttons,
  output logic        [1:0]     out_input_mode,
  output logic        [1:0]     out_frame_event,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  logic   q_full, q_push, q_pop, q_not_empty;
  frame_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_offset    <= 11'd1024;
      cfg_r.error_limit       <= 11'd700;
      cfg_r.mode_switch_index <= 1'b0;
      cfg_r.switch_up_code    <= 2'd1;
      cfg_r.switch_mid_code   <= 2'd3;
      cfg_r.switch_down_code  <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHANNEL_OFFSET:    cfg_r.channel_offset    <= cfg_wdata[10:0];
        CFG_ERROR_LIMIT:       cfg_r.error_limit       <= cfg_wdata[10:0];
        CFG_MODE_SWITCH_INDEX: cfg_r.mode_switch_index <= cfg_wdata[0];
        CFG_SWITCH_UP_CODE:    cfg_r.switch_up_code    <= cfg_wdata[1:0];
        CFG_SWITCH_MID_CODE:   cfg_r.switch_mid_code   <= cfg_wdata[1:0];
        CFG_SWITCH_DOWN_CODE:  cfg_r.switch_down_code  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  rcfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .in_line_idle (in_line_idle),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  rcfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  rcfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_not_empty      (q_not_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_stick_ch0    (out_stick_ch0),
    .out_stick_ch1    (out_stick_ch1),
    .out_stick_ch2    (out_stick_ch2),
    .out_stick_ch3    (out_stick_ch3),
    .out_wheel        (out_wheel),
    .out_switches     (out_switches),
    .out_mouse_x      (out_mouse_x),
    .out_mouse_y      (out_mouse_y),
    .out_mouse_z      (out_mouse_z),
    .out_keys_buttons (out_keys_buttons),
    .out_input_mode   (out_input_mode),
    .out_frame_event  (out_frame_event)
  );

endmodule

@@ src/rcfd_front.sv @@
// Front end: accepts received bytes and idle marks, fills the frame store and
// hands complete 18-byte frames to the queue. Depends on rcfd_pkg.
module rcfd_front import rcfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_idle,
  input  logic       q_full,
  output logic       q_push,
  output frame_t     q_wdata
);

  frame_t           store_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             accept;

  // Bytes are always taken; an idle mark waits for room in the queue.
  assign in_ready = !q_full || !in_line_idle;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && in_line_idle && (count_r == FRAME_COUNT);
  assign q_wdata  = store_r;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_line_idle) begin
        count_nxt = '0;
      end else if (count_r < BUFFER_COUNT) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_line_idle && (count_r < FRAME_COUNT)) begin
      store_r[count_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

endmodule

@@ src/rcfd_queue.sv @@
// Two-entry frame queue between the front end and the decoder.
// Depends on rcfd_pkg for the frame type and depth.
module rcfd_queue import rcfd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output frame_t rdata
);

  frame_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_LVL_W-1:0] level_r;

  assign full      = (level_r == QUEUE_LVL_W'(QUEUE_DEPTH));
  assign not_empty = (level_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                    wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                    rd_ptr_r + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + QUEUE_LVL_W'(1);
      end else if (pop && !push) begin
        level_r <= level_r - QUEUE_LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/rcfd_back.sv @@
// Decoder: unpacks a queued frame, checks it, updates the kept input mode and
// holds the result in an output register. Depends on rcfd_pkg.
module rcfd_back import rcfd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_not_empty,
  input  frame_t             q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] out_stick_ch0,
  output logic signed [11:0] out_stick_ch1,
  output logic signed [11:0] out_stick_ch2,
  output logic signed [11:0] out_stick_ch3,
  output logic signed [15:0] out_wheel,
  output logic        [3:0]  out_switches,
  output logic signed [15:0] out_mouse_x,
  output logic signed [15:0] out_mouse_y,
  output logic signed [15:0] out_mouse_z,
  output logic        [17:0] out_keys_buttons,
  output logic        [1:0]  out_input_mode,
  output logic        [1:0]  out_frame_event
);

  logic               valid_r;
  logic [1:0]         mode_r;
  logic [1:0]         mode_nxt;
  logic signed [11:0] ch_r [4];
  logic signed [11:0] ch_nxt [4];
  logic [15:0]        wheel_r, wheel_nxt;
  logic [3:0]         sw_r, sw_nxt;
  logic [15:0]        mx_r, mx_nxt, my_r, my_nxt, mz_r, mz_nxt;
  logic [17:0]        kb_r, kb_nxt;
  logic [1:0]         event_r, event_nxt;

  logic [10:0]        raw [4];
  logic signed [11:0] ch [4];
  logic [10:0]        mag [4];
  logic [1:0]         sw0, sw1, sel;
  logic               combo, bad;
  frame_t             b;

  assign b     = q_rdata;
  assign q_pop = q_not_empty && (!valid_r || out_ready);

  always_comb begin
    raw[0] = {b[1][2:0], b[0]} & RAW_MASK;
    raw[1] = {b[2][5:0], b[1][7:3]} & RAW_MASK;
    raw[2] = {b[4][0], b[3], b[2][7:6]} & RAW_MASK;
    raw[3] = {b[5][3:0], b[4][7:1]} & RAW_MASK;
    sw0    = b[5][5:4];
    sw1    = b[5][7:6];
    bad    = (sw0 == 2'd0) || (sw1 == 2'd0);
    for (int i = 0; i < 4; i++) begin
      ch[i]  = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg.channel_offset});
      mag[i] = ch[i][11] ? 11'(-ch[i]) : ch[i][10:0];
      if (mag[i] > cfg.error_limit) begin
        bad = 1'b1;
      end
    end
    combo = (ch[0] == COMBO_LOW) && (ch[1] == COMBO_LOW) &&
            (ch[2] == COMBO_HIGH) && (ch[3] == COMBO_LOW);
    sel   = cfg.mode_switch_index ? sw1 : sw0;

    mode_nxt = mode_r;
    if (!combo) begin
      if (sel == cfg.switch_up_code) begin
        mode_nxt = MODE_KEYBOARD_MOUSE;
      end else if (sel == cfg.switch_mid_code) begin
        mode_nxt = MODE_REMOTE;
      end else if (sel == cfg.switch_down_code) begin
        mode_nxt = MODE_STOPPED;
      end
    end

    for (int i = 0; i < 4; i++) begin
      ch_nxt[i] = ch[i];
    end
    wheel_nxt = {b[17], b[16]} - {5'd0, cfg.channel_offset};
    sw_nxt    = {sw1, sw0};
    mx_nxt    = {b[7], b[6]};
    my_nxt    = {b[9], b[8]};
    mz_nxt    = {b[11], b[10]};
    kb_nxt    = {(b[13] != 8'd0), (b[12] != 8'd0), b[15], b[14]};
    event_nxt = combo ? EV_COMBO : EV_VALID;

    // A corrupt frame reports zeros with both levers forced down.
    if (!combo && bad) begin
      for (int i = 0; i < 4; i++) begin
        ch_nxt[i] = '0;
      end
      wheel_nxt = '0;
      sw_nxt    = {cfg.switch_down_code, cfg.switch_down_code};
      mx_nxt    = '0;
      my_nxt    = '0;
      mz_nxt    = '0;
      kb_nxt    = '0;
      event_nxt = EV_CORRUPT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mode_r  <= MODE_STOPPED;
    end else begin
      if (q_pop) begin
        valid_r <= 1'b1;
        mode_r  <= mode_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 4; i++) begin
        ch_r[i] <= ch_nxt[i];
      end
      wheel_r <= wheel_nxt;
      sw_r    <= sw_nxt;
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
      mz_r    <= mz_nxt;
      kb_r    <= kb_nxt;
      event_r <= event_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_stick_ch0    = ch_r[0];
  assign out_stick_ch1    = ch_r[1];
  assign out_stick_ch2    = ch_r[2];
  assign out_stick_ch3    = ch_r[3];
  assign out_wheel        = $signed(wheel_r);
  assign out_switches     = sw_r;
  assign out_mouse_x      = $signed(mx_r);
  assign out_mouse_y      = $signed(my_r);
  assign out_mouse_z      = $signed(mz_r);
  assign out_keys_buttons = kb_r;
  assign out_input_mode   = mode_r;
  assign out_frame_event  = event_r;

endmodule

@@ src/rcfd_checker.sv @@
// Port-level checker for the frame decoder and its bind to the top level.
// Depends on rcfd_pkg and rc_receiver_frame_decoder_core.
module rcfd_checker import rcfd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [11:0]    out_stick_ch0,
  input logic signed [11:0]    out_stick_ch1,
  input logic signed [11:0]    out_stick_ch2,
  input logic signed [11:0]    out_stick_ch3,
  input logic signed [15:0]    out_wheel,
  input logic        [3:0]     out_switches,
  input logic signed [15:0]    out_mouse_x,
  input logic signed [15:0]    out_mouse_y,
  input logic signed [15:0]    out_mouse_z,
  input logic        [17:0]    out_keys_buttons,
  input logic        [1:0]     out_input_mode,
  input logic        [1:0]     out_frame_event
);

  // A pending result transaction holds its payload until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_event) &&
      $stable(out_input_mode) && $stable(out_keys_buttons))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A corrupt frame reports zeroed fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_event == EV_CORRUPT) |->
      out_stick_ch0 == 0 && out_stick_ch1 == 0 && out_stick_ch2 == 0 &&
      out_stick_ch3 == 0 && out_wheel == 0 && out_mouse_x == 0 &&
      out_mouse_y == 0 && out_mouse_z == 0 && out_keys_buttons == 0)
    else $error("corrupt frame not zeroed");

  // A frame reported as valid never carries a zero switch.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_event == EV_VALID) |->
      out_switches[1:0] != 2'd0 && out_switches[3:2] != 2'd0)
    else $error("valid frame with zero switch");

endmodule

bind rc_receiver_frame_decoder_core rcfd_checker u_rcfd_checker (.*);

@@ dv/rc_receiver_frame_decoder_core_test.sv @@
// Self-checking testbench for rc_receiver_frame_decoder_core: directed frames, then random
// frame traffic under several register settings and idle patterns, checked against a predictor.
// Depends on rcfd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module rc_receiver_frame_decoder_core_test;
  import rcfd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 410;

  // Indexes past the register list; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 3'd7;

  localparam cfg_t CFG_LIMIT_OPEN = '{channel_offset: 11'd1024, error_limit: 11'd2047,
    mode_switch_index: 1'b1, switch_up_code: 2'd3, switch_mid_code: 2'd1,
    switch_down_code: 2'd0};
  localparam cfg_t CFG_ZERO_CENTER = '{channel_offset: 11'd0, error_limit: 11'd0,
    mode_switch_index: 1'b0, switch_up_code: 2'd2, switch_mid_code: 2'd2,
    switch_down_code: 2'd1};
  localparam cfg_t CFG_HIGH_CENTER = '{channel_offset: 11'd2047, error_limit: 11'd1500,
    mode_switch_index: 1'b1, switch_up_code: 2'd0, switch_mid_code: 2'd3,
    switch_down_code: 2'd3};
  localparam cfg_t CFG_DEFAULTS = '{channel_offset: 11'd1024, error_limit: 11'd700,
    mode_switch_index: 1'b0, switch_up_code: 2'd1, switch_mid_code: 2'd3,
    switch_down_code: 2'd2};

  typedef struct packed {
    logic signed [11:0] stick0;
    logic signed [11:0] stick1;
    logic signed [11:0] stick2;
    logic signed [11:0] stick3;
    logic signed [15:0] wheel;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [17:0]        keys_buttons;
    logic [1:0]         input_mode;
    logic [1:0]         frame_event;
  } frame_result_t;

  typedef struct packed {
    logic          typed;
    frame_result_t want;
  } idle_tag_t;

  typedef struct {
    int            nbytes;
    frame_t        bytes;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic in_line_idle = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [11:0] out_stick_ch0, out_stick_ch1, out_stick_ch2, out_stick_ch3;
  logic signed [15:0] out_wheel;
  logic [3:0] out_switches;
  logic signed [15:0] out_mouse_x, out_mouse_y, out_mouse_z;
  logic [17:0] out_keys_buttons;
  logic [1:0] out_input_mode;
  logic [1:0] out_frame_event;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rc_receiver_frame_decoder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_byte(in_rx_byte), .in_line_idle(in_line_idle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_stick_ch0(out_stick_ch0), .out_stick_ch1(out_stick_ch1),
    .out_stick_ch2(out_stick_ch2), .out_stick_ch3(out_stick_ch3),
    .out_wheel(out_wheel), .out_switches(out_switches),
    .out_mouse_x(out_mouse_x), .out_mouse_y(out_mouse_y), .out_mouse_z(out_mouse_z),
    .out_keys_buttons(out_keys_buttons), .out_input_mode(out_input_mode),
    .out_frame_event(out_frame_event),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow of the block's registers and state.
  cfg_t       cfg_now = CFG_DEFAULTS;
  logic [1:0] mode_now = MODE_STOPPED;
  frame_t     rx_store;
  int         rx_count = 0;

  frame_result_t decoded_q[$];
  idle_tag_t     idle_tags_q[$];
  stim_row_t     directed_rows[$];

  int fail_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_request = 1'b0;

  function automatic frame_t pack_frame(logic [10:0] r0, logic [10:0] r1, logic [10:0] r2,
                                        logic [10:0] r3, logic [1:0] s0, logic [1:0] s1,
                                        logic [95:0] tail);
    return {tail, s1, s0, r3, r2, r1, r0};
  endfunction

  // The first six bytes form one little-endian bit stream of four 11-bit channels and
  // two 2-bit switches.
  function automatic frame_result_t decode_frame(frame_t f);
    logic [47:0]   bits;
    logic [1:0]    sw [2];
    logic [1:0]    sel;
    int            ch [4];
    int            i;
    logic          bad;
    frame_result_t r;
    bits = f[5:0];
    for (i = 0; i < 4; i++) begin
      ch[i] = int'(bits[11*i +: 11]) - int'(cfg_now.channel_offset);
    end
    sw[0] = bits[45:44];
    sw[1] = bits[47:46];
    r.stick0 = 12'(ch[0]);
    r.stick1 = 12'(ch[1]);
    r.stick2 = 12'(ch[2]);
    r.stick3 = 12'(ch[3]);
    r.wheel = {f[17], f[16]} - {5'd0, cfg_now.channel_offset};
    r.switches = {sw[1], sw[0]};
    r.mouse_x = {f[7], f[6]};
    r.mouse_y = {f[9], f[8]};
    r.mouse_z = {f[11], f[10]};
    r.keys_buttons = {|f[13], |f[12], f[15], f[14]};
    if (ch[0] == int'(COMBO_LOW) && ch[1] == int'(COMBO_LOW) &&
        ch[2] == int'(COMBO_HIGH) && ch[3] == int'(COMBO_LOW)) begin
      r.frame_event = EV_COMBO;
    end else begin
      r.frame_event = EV_VALID;
      sel = sw[cfg_now.mode_switch_index];
      if (sel == cfg_now.switch_up_code) begin
        mode_now = MODE_KEYBOARD_MOUSE;
      end else if (sel == cfg_now.switch_mid_code) begin
        mode_now = MODE_REMOTE;
      end else if (sel == cfg_now.switch_down_code) begin
        mode_now = MODE_STOPPED;
      end
      bad = (sw[0] == 2'd0) || (sw[1] == 2'd0);
      for (i = 0; i < 4; i++) begin
        if ((ch[i] < 0 ? -ch[i] : ch[i]) > int'(cfg_now.error_limit)) bad = 1'b1;
      end
      if (bad) begin
        r = '0;
        r.switches = {cfg_now.switch_down_code, cfg_now.switch_down_code};
        r.frame_event = EV_CORRUPT;
      end
    end
    r.input_mode = mode_now;
    return r;
  endfunction

  // Sticks mostly land near the center so that many frames pass the limit check.
  function automatic logic [10:0] pick_raw();
    int v;
    int lim;
    lim = int'(cfg_now.error_limit);
    case ($urandom_range(9))
      0: v = $urandom_range(2047);
      1: v = $urandom_range(1) ? 2047 : 0;
      default: v = int'(cfg_now.channel_offset) - lim - 2 + int'($urandom_range(2 * lim + 4));
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return 11'(v);
  endfunction

  function automatic frame_t random_frame();
    logic [10:0] r [4];
    logic [1:0]  s [2];
    logic [95:0] tail;
    int          off;
    int          i;
    off = int'(cfg_now.channel_offset);
    for (i = 0; i < 4; i++) r[i] = pick_raw();
    if ($urandom_range(19) == 0 && off >= 660 && off + 660 <= 2047) begin
      r[0] = 11'(off - 660);
      r[1] = 11'(off - 660);
      r[2] = 11'(off + 660);
      r[3] = 11'(off - 660);
    end
    for (i = 0; i < 2; i++) s[i] = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    tail = {$urandom, $urandom, $urandom};
    // Bytes 12 and 13 carry the mouse buttons; make released buttons common.
    if ($urandom_range(3) == 0) tail[55:48] = '0;
    if ($urandom_range(3) == 0) tail[63:56] = '0;
    return pack_frame(r[0], r[1], r[2], r[3], s[0], s[1], tail);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // All driving tasks are entered just after a rising edge.
  task automatic send_item(logic [7:0] b, logic idle);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_line_idle <= idle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame(int n, frame_t f, logic typed, frame_result_t want);
    int i;
    for (i = 0; i < n; i++) begin
      send_item((i < FRAME_BYTES) ? f[i] : 8'($urandom), 1'b0);
    end
    idle_tags_q.push_back('{typed, want});
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic send_random_frame();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 85) n = FRAME_BYTES;
    else if (pick < 90) n = $urandom_range(FRAME_BYTES - 1);
    else if (pick < 95) n = $urandom_range(FRAME_BYTES + 1, 40);
    else if (pick < 97) n = $urandom_range(60, 90);
    else n = 0;
    send_frame(n, random_frame(), 1'b0, '0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Narrow registers get random upper bits, which the block must mask off.
  task automatic apply_config(cfg_t c, logic add_spare);
    write_reg(CFG_CHANNEL_OFFSET, c.channel_offset);
    write_reg(CFG_ERROR_LIMIT, c.error_limit);
    write_reg(CFG_MODE_SWITCH_INDEX, {10'($urandom), c.mode_switch_index});
    write_reg(CFG_SWITCH_UP_CODE, {9'($urandom), c.switch_up_code});
    write_reg(CFG_SWITCH_MID_CODE, {9'($urandom), c.switch_mid_code});
    write_reg(CFG_SWITCH_DOWN_CODE, {9'($urandom), c.switch_down_code});
    if (add_spare) begin
      write_reg(CFG_SPARE_LOW, 11'($urandom));
      write_reg(CFG_SPARE_HIGH, 11'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int goal);
    int start;
    start = items_sent;
    while (items_sent - start < goal) send_random_frame();
  endtask

  task automatic add_row(int n, frame_t f, logic typed, frame_result_t want);
    stim_row_t row;
    row.nbytes = n;
    row.bytes = f;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Directed frames under the reset register values.
  task automatic load_directed_rows();
    add_row(0, random_frame(), 1'b0, '0);
    // All-zero frame: both switches zero and every stick far off center.
    add_row(FRAME_BYTES, '0, 1'b1, '{switches: 4'b1010, input_mode: MODE_STOPPED,
            frame_event: EV_CORRUPT, default: '0});
    // All-ones frame: switch zero reads the mid code, so the mode moves to remote.
    add_row(FRAME_BYTES, '1, 1'b1, '{switches: 4'b1010, input_mode: MODE_REMOTE,
            frame_event: EV_CORRUPT, default: '0});
    // Sticks-inward combo: fields pass through and the mode is kept.
    add_row(FRAME_BYTES, pack_frame(11'd364, 11'd364, 11'd1684, 11'd364, 2'd1, 2'd1,
            {8'h04, 8'h00, 8'ha5, 8'h5a, 8'h80, 8'h01, 8'hff, 8'hff, 8'h7f, 8'hff,
             8'h80, 8'h00}),
            1'b1, '{stick0: COMBO_LOW, stick1: COMBO_LOW, stick2: COMBO_HIGH,
            stick3: COMBO_LOW, wheel: 16'sd0, switches: 4'b0101, mouse_x: 16'h8000,
            mouse_y: 16'h7fff, mouse_z: 16'hffff, keys_buttons: 18'h3a55a,
            input_mode: MODE_REMOTE, frame_event: EV_COMBO});
    add_row(FRAME_BYTES, pack_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd3,
            {$urandom, $urandom, $urandom}), 1'b0, '0);
    // Sticks exactly at the limit are still good.
    add_row(FRAME_BYTES, pack_frame(11'd324, 11'd1724, 11'd1724, 11'd324, 2'd3, 2'd2,
            {$urandom, $urandom, $urandom}), 1'b0, '0);
    add_row(FRAME_BYTES, pack_frame(11'd1024, 11'd1024, 11'd1725, 11'd1024, 2'd2, 2'd1,
            {$urandom, $urandom, $urandom}), 1'b0, '0);
    add_row(FRAME_BYTES, pack_frame(11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd0,
            {$urandom, $urandom, $urandom}), 1'b0, '0);
    add_row(FRAME_BYTES - 1, random_frame(), 1'b0, '0);
    add_row(FRAME_BYTES + 1, random_frame(), 1'b0, '0);
    // Long enough to saturate the count and to pass a 6-bit wrap back to 18.
    add_row(82, random_frame(), 1'b0, '0);
    add_row(FRAME_BYTES, random_frame(), 1'b0, '0);
    add_row(FRAME_BYTES, pack_frame(11'd364, 11'd364, 11'd1684, 11'd364, 2'($urandom),
            2'($urandom), {$urandom, $urandom, $urandom}), 1'b0, '0);
    // One count away from the combo is an ordinary frame.
    add_row(FRAME_BYTES, pack_frame(11'd364, 11'd364, 11'd1684, 11'd365, 2'd1, 2'd1,
            {$urandom, $urandom, $urandom}), 1'b0, '0);
  endtask

  always @(posedge clk) begin : cfg_shadow
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHANNEL_OFFSET:    cfg_now.channel_offset = cfg_wdata;
        CFG_ERROR_LIMIT:       cfg_now.error_limit = cfg_wdata;
        CFG_MODE_SWITCH_INDEX: cfg_now.mode_switch_index = cfg_wdata[0];
        CFG_SWITCH_UP_CODE:    cfg_now.switch_up_code = cfg_wdata[1:0];
        CFG_SWITCH_MID_CODE:   cfg_now.switch_mid_code = cfg_wdata[1:0];
        CFG_SWITCH_DOWN_CODE:  cfg_now.switch_down_code = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : byte_collector
    idle_tag_t     tag;
    frame_result_t decoded;
    if (rst_n && in_valid && in_ready) begin
      if (!in_line_idle) begin
        if (rx_count < FRAME_BYTES) rx_store[rx_count] = in_rx_byte;
        if (rx_count < BUFFER_BYTES) rx_count++;
      end else begin
        tag = idle_tags_q.pop_front();
        if (rx_count == FRAME_BYTES) begin
          decoded = decode_frame(rx_store);
          decoded_q.push_back(tag.typed ? tag.want : decoded);
        end
        rx_count = 0;
      end
    end
  end

  always @(posedge clk) begin : result_checker
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("result transaction with no decoded frame pending");
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("stick_ch0", 32'(want.stick0), 32'(out_stick_ch0));
        check_field("stick_ch1", 32'(want.stick1), 32'(out_stick_ch1));
        check_field("stick_ch2", 32'(want.stick2), 32'(out_stick_ch2));
        check_field("stick_ch3", 32'(want.stick3), 32'(out_stick_ch3));
        check_field("wheel", 32'(want.wheel), 32'(out_wheel));
        check_field("switches", 32'(want.switches), 32'(out_switches));
        check_field("mouse_x", 32'(want.mouse_x), 32'(out_mouse_x));
        check_field("mouse_y", 32'(want.mouse_y), 32'(out_mouse_y));
        check_field("mouse_z", 32'(want.mouse_z), 32'(out_mouse_z));
        check_field("keys_buttons", 32'(want.keys_buttons), 32'(out_keys_buttons));
        check_field("input_mode", 32'(want.input_mode), 32'(out_input_mode));
        check_field("frame_event", 32'(want.frame_event), 32'(out_frame_event));
      end
    end
  end

  // Output back-pressure, including one long hold-off that fills the frame queue.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rc_receiver_frame_decoder_core_test: done, errors");
    $finish;
  end

  initial begin : main
    int i;
    load_directed_rows();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < directed_rows.size(); i++) begin
      send_frame(directed_rows[i].nbytes, directed_rows[i].bytes, directed_rows[i].typed,
                 directed_rows[i].want);
    end
    wait_drained();

    apply_config(CFG_LIMIT_OPEN, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    run_random(PHASE_ITEMS);
    wait_drained();

    apply_config(CFG_ZERO_CENTER, 1'b0);
    send_idle_pct = 49;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);
    wait_drained();

    apply_config(CFG_HIGH_CENTER, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    run_random(PHASE_ITEMS);
    wait_drained();

    apply_config(CFG_DEFAULTS, 1'b1);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    run_random(PHASE_ITEMS);
    wait_drained();

    if (fail_count == 0) begin
      $display("rc_receiver_frame_decoder_core_test: done, clean");
    end else begin
      $display("rc_receiver_frame_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule
